// ===== hdl/audio_level_meter_assert.svh =====
// Assertion macros for the level meter.
// Depends on signals named clk and rst in the module that uses them.
`ifndef AUDIO_LEVEL_METER_ASSERT_SVH
`define AUDIO_LEVEL_METER_ASSERT_SVH
`ifndef SYNTHESIS
`define ALM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("level meter assertion failed");
`define ALM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("level meter assertion failed");
`else
`define ALM_ASSERT_IMP(label, ante, cons)
`define ALM_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== hdl/alm_pkg.sv =====
// Shared types, constants and codes of the audio level meter.
// No dependencies.
package alm_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int LVL_W         = 24;
  localparam int MS_W          = 48;
  localparam int SUM_W         = 58;
  localparam int DEF_CHANNELS  = 8;
  localparam int DEF_MAX_BLOCK = 4096;

  localparam logic [2:0] CFG_ACTIVE     = 3'd0;
  localparam logic [2:0] CFG_RMS_COEFF  = 3'd1;
  localparam logic [2:0] CFG_PEAK_DECAY = 3'd2;
  localparam logic [2:0] CFG_HOLD_DECAY = 3'd3;
  localparam logic [2:0] CFG_HOLD_BLK   = 3'd4;
  localparam logic [2:0] CFG_CLIP_THR   = 3'd5;
  localparam logic [2:0] CFG_CLIP_HOLD  = 3'd6;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  typedef struct packed {
    logic                          func;
    logic [2:0]                    channel;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in_block;
  } in_t;

  typedef struct packed {
    logic [2:0]       out_channel;
    logic [LVL_W-1:0] peak;
    logic [LVL_W-1:0] peak_hold;
    logic [LVL_W-1:0] rms;
    logic             clip;
  } out_t;

  typedef struct packed {
    logic [3:0]       active_channels;
    logic [23:0]      rms_coeff;
    logic [15:0]      peak_decay;
    logic [15:0]      hold_decay;
    logic [15:0]      hold_blocks;
    logic [LVL_W-1:0] clip_threshold;
    logic [15:0]      clip_hold_blocks;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic             clear;
    logic [2:0]       channel;
    logic [LVL_W-1:0] mag;
    logic             last;
  } cmd_t;

  // per-channel state except the sample count
  typedef struct packed {
    logic [MS_W-1:0]  mean_square;
    logic [LVL_W-1:0] block_peak;
    logic [SUM_W-1:0] block_sum_sq;
    logic             primed;
    logic [LVL_W-1:0] peak_level;
    logic [LVL_W-1:0] hold_level;
    logic [15:0]      hold_left;
    logic             clip_latch;
    logic [15:0]      clip_age;
  } rec_t;

  typedef enum logic [3:0] {
    B_IDLE, B_READ, B_SQ, B_DIFF, B_LO, B_HI, B_UPD,
    B_DIVI, B_DIV, B_PK, B_HD, B_BAL, B_ROOT, B_WR
  } back_state_t;

endpackage

// ===== hdl/alm_fifo.sv =====
// Small register FIFO used for the item queue and the result queue.
// No package dependency.
module alm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== hdl/alm_front.sv =====
// Front end: accepts items, drops inactive channels, takes the sample
// magnitude and queues the classified item. Uses alm_pkg and alm_fifo.
module alm_front import alm_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_t        item,
  input  logic [3:0] active_channels,
  input  logic       cmd_pop,
  output logic       cmd_empty,
  output cmd_t       cmd
);
  cmd_t                 cls;
  logic                 keep;
  logic [LVL_W-1:0]     cmd_bits_unused;
  logic [$bits(cmd_t)-1:0] rd_bits;

  assign keep = ({1'b0, item.channel} < active_channels) &&
                (32'(item.channel) < CHANNELS);

  always_comb begin
    cls.clear   = (item.func == FUNC_CLEAR);
    cls.channel = item.channel;
    cls.last    = item.last_in_block;
    // most negative sample maps to 2^23, which still fits
    cls.mag     = item.sample[SAMPLE_BITS-1] ? LVL_W'(~item.sample + 1'b1)
                                             : LVL_W'(item.sample);
  end

  assign cmd_bits_unused = '0;

  alm_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (4)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full && keep),
    .wr_data (cls),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (rd_bits),
    .empty   (cmd_empty)
  );

  assign cmd = cmd_t'(rd_bits | $bits(cmd_t)'(cmd_bits_unused));

endmodule

// ===== hdl/alm_root.sv =====
// Iterative square root, two bits of the radicand per cycle, rounded
// to nearest. Uses alm_pkg.
module alm_root import alm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MS_W-1:0]  value,
  output logic             done,
  output logic [LVL_W-1:0] root
);
  logic            busy;
  logic [MS_W-1:0] v;
  logic [MS_W-1:0] r;
  logic [MS_W-1:0] bitv;
  logic [MS_W:0]   trial;
  logic [MS_W-1:0] v_next;
  logic [MS_W-1:0] r_next;
  logic [MS_W:0]   r_up;

  always_comb begin
    trial = {1'b0, r} + {1'b0, bitv};
    if ({1'b0, v} >= trial) begin
      v_next = v - trial[MS_W-1:0];
      r_next = (r >> 1) + bitv;
    end else begin
      v_next = v;
      r_next = r >> 1;
    end
    r_up = {1'b0, r_next} + ((v_next > r_next) ? (MS_W+1)'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= value;
      r    <= '0;
      bitv <= MS_W'(1) << (MS_W - 2);
    end else if (busy) begin
      v    <= v_next;
      r    <= r_next;
      bitv <= bitv >> 2;
      if (bitv[0]) begin
        root <= r_up[LVL_W-1:0];
      end
    end
  end

endmodule

// ===== hdl/alm_back.sv =====
// Back end: per-channel state memory and the sequencer that runs the
// smoother, block close, seeding divide and ballistics. Uses alm_pkg, alm_root.
module alm_back import alm_pkg::*; #(
  parameter int CHANNELS  = DEF_CHANNELS,
  parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  cmd_t cmd,
  input  logic cmd_empty,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output out_t res
);
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int NUM_W = SUM_W + 1;
  localparam int DIV_W = $clog2(NUM_W);

  back_state_t state, state_next;

  rec_t             mem     [CHANNELS];
  logic [CNT_W-1:0] cnt_mem [CHANNELS];
  logic [CHANNELS-1:0] valid;
  rec_t             rd_rec;
  logic [CNT_W-1:0] rd_cnt;
  logic             rd_valid;
  rec_t             rd_start;

  cmd_t             cur;
  logic [CH_W-1:0]  addr;
  logic [CH_W-1:0]  cmd_idx;
  rec_t             w;
  logic [CNT_W-1:0] cnt;
  logic [MS_W-1:0]  dif;
  logic             up;
  logic             close;
  logic [23:0]      mul_a;
  logic [23:0]      mul_b;
  logic [47:0]      prod;
  logic [24:0]      lo_part;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] rem;
  logic [DIV_W-1:0] div_i;

  logic [MS_W:0]    step_sum;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W:0]   rem_sh;
  logic             rem_ge;
  logic [LVL_W-1:0] dec_lvl;
  logic [15:0]      left_dec;
  logic [15:0]      age_inc;
  logic             root_start;
  logic             root_done;
  logic [LVL_W-1:0] root_val;
  rec_t             wr_rec;

  assign cmd_idx  = CH_W'(cmd.channel);
  assign step_sum = {1'b0, prod} + (MS_W+1)'(lo_part);
  assign cnt_inc  = cnt + 1'b1;
  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, cnt});
  assign dec_lvl  = prod[16 +: LVL_W];
  assign left_dec = (w.hold_left != '0) ? w.hold_left - 1'b1 : w.hold_left;
  assign age_inc  = (w.clip_age != 16'hFFFF) ? w.clip_age + 1'b1 : w.clip_age;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!cmd_empty && !res_full) state_next = B_READ;
      B_READ: state_next = cur.clear ? B_WR : B_SQ;
      B_SQ:   state_next = B_DIFF;
      B_DIFF: state_next = B_LO;
      B_LO:   state_next = B_HI;
      B_HI:   state_next = B_UPD;
      B_UPD: begin
        if (cur.last || cnt_inc >= CNT_W'(MAX_BLOCK)) begin
          state_next = w.primed ? B_PK : B_DIVI;
        end else begin
          state_next = B_WR;
        end
      end
      B_DIVI: state_next = B_DIV;
      B_DIV:  if (div_i == DIV_W'(NUM_W - 1)) state_next = B_PK;
      B_PK:   state_next = B_HD;
      B_HD:   state_next = B_BAL;
      B_BAL:  state_next = B_ROOT;
      B_ROOT: if (root_done) state_next = B_WR;
      B_WR:   state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    root_start = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      B_IDLE: cmd_pop = !cmd_empty && !res_full;
      B_SQ: begin
        mul_a = cur.mag;
        mul_b = cur.mag;
      end
      B_LO: begin
        mul_a = cfg.rms_coeff;
        mul_b = dif[23:0];
      end
      B_HI: begin
        mul_a = cfg.rms_coeff;
        mul_b = dif[47:24];
      end
      B_PK: begin
        mul_a = w.peak_level;
        mul_b = {8'b0, cfg.peak_decay};
      end
      B_HD: begin
        mul_a = w.hold_level;
        mul_b = {8'b0, cfg.hold_decay};
      end
      B_BAL: root_start = 1'b1;
      B_WR:  res_push = close;
      default: ;
    endcase
  end

  // record as loaded, with a manual clear applied
  always_comb begin
    rd_start = rd_valid ? rd_rec : '0;
    if (cur.clear) begin
      rd_start.clip_latch = 1'b0;
    end
  end

  always_comb begin
    wr_rec = w;
    if (close) begin
      wr_rec.block_peak   = '0;
      wr_rec.block_sum_sq = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      valid <= '0;
    end else begin
      state <= state_next;
      if (state == B_WR) begin
        valid[addr] <= 1'b1;
      end
    end
  end

  // state memory, registered read
  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      rd_rec   <= mem[cmd_idx];
      rd_cnt   <= cnt_mem[cmd_idx];
      rd_valid <= valid[cmd_idx];
    end
    if (state == B_WR) begin
      mem[addr]     <= wr_rec;
      cnt_mem[addr] <= close ? '0 : cnt;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      B_IDLE: begin
        cur  <= cmd;
        addr <= cmd_idx;
      end
      B_READ: begin
        close <= 1'b0;
        w     <= rd_start;
        cnt   <= rd_valid ? rd_cnt : '0;
      end
      B_DIFF: begin
        // prod holds the square; dif takes its distance from the mean square
        up  <= (prod >= w.mean_square);
        dif <= (prod >= w.mean_square) ? prod - w.mean_square : w.mean_square - prod;
        w.block_sum_sq <= (({1'b0, w.block_sum_sq} + (SUM_W+1)'(prod)) >> SUM_W) != '0
                          ? '1 : w.block_sum_sq + SUM_W'(prod);
      end
      B_HI: lo_part <= 25'((49'(prod) + 49'(1 << 23)) >> 24);
      B_UPD: begin
        w.mean_square <= up ? w.mean_square + step_sum[MS_W-1:0]
                            : w.mean_square - step_sum[MS_W-1:0];
        if (cur.mag > w.block_peak) begin
          w.block_peak <= cur.mag;
        end
        cnt   <= cnt_inc;
        close <= cur.last || cnt_inc >= CNT_W'(MAX_BLOCK);
      end
      B_DIVI: begin
        quo   <= {1'b0, w.block_sum_sq} + NUM_W'(cnt >> 1);
        rem   <= '0;
        div_i <= '0;
      end
      B_DIV: begin
        rem   <= rem_ge ? CNT_W'(rem_sh - {1'b0, cnt}) : rem_sh[CNT_W-1:0];
        quo   <= {quo[NUM_W-2:0], rem_ge};
        div_i <= div_i + 1'b1;
      end
      B_PK: begin
        if (!w.primed) begin
          w.mean_square <= quo[MS_W-1:0];
          w.primed      <= 1'b1;
        end
      end
      B_HD: w.peak_level <= (w.block_peak > dec_lvl) ? w.block_peak : dec_lvl;
      B_BAL: begin
        if (w.block_peak >= w.hold_level) begin
          w.hold_level <= w.block_peak;
          w.hold_left  <= cfg.hold_blocks;
        end else begin
          w.hold_left <= left_dec;
          if (left_dec == '0) begin
            w.hold_level <= dec_lvl;
          end
        end
        if (w.block_peak >= cfg.clip_threshold) begin
          w.clip_latch <= 1'b1;
          w.clip_age   <= '0;
        end else if (w.clip_latch && cfg.clip_hold_blocks != '0) begin
          w.clip_age <= age_inc;
          if (age_inc >= cfg.clip_hold_blocks) begin
            w.clip_latch <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  alm_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (w.mean_square),
    .done  (root_done),
    .root  (root_val)
  );

  always_comb begin
    res.out_channel = cur.channel;
    res.peak        = w.peak_level;
    res.peak_hold   = w.hold_level;
    res.rms         = root_val;
    res.clip        = w.clip_latch;
  end

endmodule

// ===== hdl/audio_level_meter.sv =====
// Per-channel audio level meter: peak, peak hold, RMS and clip per closed
// block. Items go into a four-deep queue; a sequencer with one shared 24x24
// multiplier takes one item at a time. A clear skips the arithmetic; a
// block-closing sample also runs the 24-step square root, and a channel's
// first block also runs the bit-serial seeding divide. Results wait in a
// two-deep queue. Depends on alm_pkg, alm_fifo, alm_front and alm_back.
module audio_level_meter import alm_pkg::*; #(
  parameter int CHANNELS  = DEF_CHANNELS,
  parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_t         item,
  output logic        empty,
  input  logic        pop,
  output out_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  `include "audio_level_meter_assert.svh"

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_pop;
  logic cmd_empty;
  logic res_push;
  logic res_full;
  out_t res;
  logic [$bits(out_t)-1:0] res_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_channels  <= 4'd8;
      cfg.rms_coeff        <= 24'd1165;
      cfg.peak_decay       <= 16'd60000;
      cfg.hold_decay       <= 16'd60000;
      cfg.hold_blocks      <= 16'd100;
      cfg.clip_threshold   <= 24'd8388607;
      cfg.clip_hold_blocks <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACTIVE:     cfg.active_channels  <= cfg_data[3:0];
        CFG_RMS_COEFF:  cfg.rms_coeff        <= cfg_data;
        CFG_PEAK_DECAY: cfg.peak_decay       <= cfg_data[15:0];
        CFG_HOLD_DECAY: cfg.hold_decay       <= cfg_data[15:0];
        CFG_HOLD_BLK:   cfg.hold_blocks      <= cfg_data[15:0];
        CFG_CLIP_THR:   cfg.clip_threshold   <= cfg_data;
        CFG_CLIP_HOLD:  cfg.clip_hold_blocks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  alm_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .item            (item),
    .active_channels (cfg.active_channels),
    .cmd_pop         (cmd_pop),
    .cmd_empty       (cmd_empty),
    .cmd             (cmd)
  );

  alm_back #(
    .CHANNELS  (CHANNELS),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  alm_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_bits),
    .empty   (empty)
  );

  assign result = out_t'(res_bits);

  `ALM_ASSERT_IMP(a_res_room, res_push, !res_full)
  `ALM_ASSERT_IMP(a_cmd_avail, cmd_pop, !cmd_empty)
  `ALM_ASSERT_NXT(a_one_at_a_time, cmd_pop, !cmd_pop)

endmodule

// ===== dv/audio_level_meter_tb.sv =====
// Self-checking bench for audio_level_meter: directed and random samples,
// clears and register settings, checked against a per-channel level predictor.
// Depends on alm_pkg and the audio_level_meter RTL.
module audio_level_meter_tb;
  import alm_pkg::*;

  localparam int NCH       = 8;
  localparam int BLOCK_MAX = 4096;
  localparam int IDLE_WAIT = 200;
  localparam int WD_LIMIT  = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_t         item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_t        result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_ACTIVE;
  logic [23:0] cfg_data = '0;

  audio_level_meter dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  class level_scoreboard;
    bit [63:0] active, coeff, pk_decay, hd_decay, hd_blocks, clip_thr, clip_hold;
    bit [63:0] ms[NCH], blk_peak[NCH], blk_sum[NCH], count[NCH];
    bit        primed[NCH], latch[NCH];
    bit [63:0] peak_lvl[NCH], hold_lvl[NCH], hold_left[NCH], clip_age[NCH];
    out_t      pending[$];
    int        errors, n_results, n_clips;

    function new();
      active = 8; coeff = 1165; pk_decay = 60000; hd_decay = 60000;
      hd_blocks = 100; clip_thr = 8388607; clip_hold = 0;
      foreach (ms[i]) begin
        ms[i] = 0; blk_peak[i] = 0; blk_sum[i] = 0; count[i] = 0;
        primed[i] = 0; latch[i] = 0; peak_lvl[i] = 0; hold_lvl[i] = 0;
        hold_left[i] = 0; clip_age[i] = 0;
      end
      errors = 0; n_results = 0; n_clips = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    function void set_reg(logic [2:0] idx, bit [23:0] v);
      case (idx)
        CFG_ACTIVE:     active = v & 24'hF;
        CFG_RMS_COEFF:  coeff = v;
        CFG_PEAK_DECAY: pk_decay = v & 24'hFFFF;
        CFG_HOLD_DECAY: hd_decay = v & 24'hFFFF;
        CFG_HOLD_BLK:   hd_blocks = v & 24'hFFFF;
        CFG_CLIP_THR:   clip_thr = v;
        CFG_CLIP_HOLD:  clip_hold = v & 24'hFFFF;
        default: ;
      endcase
    endfunction

    function bit [63:0] smooth(bit [63:0] c, bit [63:0] d);
      return c * (d >> 24) + ((c * (d & 64'hFFFFFF) + (64'h1 << 23)) >> 24);
    endfunction

    function bit [63:0] root_round(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return (v > r) ? r + 1 : r;
    endfunction

    function void note_input(in_t x);
      int        c;
      longint    s;
      bit [63:0] mag, sq, pk, dec, rt;
      out_t      o;
      c = x.channel;
      if (c >= active) return;
      if (x.func == FUNC_CLEAR) begin
        latch[c] = 0;
        return;
      end
      s = longint'(x.sample);
      mag = (s < 0) ? -s : s;
      sq = mag * mag;
      if (mag > blk_peak[c]) blk_peak[c] = mag;
      blk_sum[c] += sq;
      if (blk_sum[c] > (64'h1 << 58) - 1) blk_sum[c] = (64'h1 << 58) - 1;
      count[c]++;
      if (sq >= ms[c]) ms[c] += smooth(coeff, sq - ms[c]);
      else             ms[c] -= smooth(coeff, ms[c] - sq);
      if (!x.last_in_block && count[c] < BLOCK_MAX) return;

      if (!primed[c]) begin
        ms[c] = (blk_sum[c] + count[c] / 2) / count[c];
        primed[c] = 1;
      end
      pk = blk_peak[c];
      dec = (peak_lvl[c] * pk_decay) >> 16;
      peak_lvl[c] = (pk > dec) ? pk : dec;
      if (pk >= hold_lvl[c]) begin
        hold_lvl[c] = pk;
        hold_left[c] = hd_blocks;
      end else begin
        if (hold_left[c] > 0) hold_left[c]--;
        if (hold_left[c] == 0) hold_lvl[c] = (hold_lvl[c] * hd_decay) >> 16;
      end
      if (pk >= clip_thr) begin
        latch[c] = 1;
        clip_age[c] = 0;
      end else if (latch[c] && clip_hold > 0) begin
        if (clip_age[c] < 64'hFFFF) clip_age[c]++;
        if (clip_age[c] >= clip_hold) latch[c] = 0;
      end
      rt = root_round(ms[c]);
      o.out_channel = 3'(c);
      o.peak        = peak_lvl[c][23:0];
      o.peak_hold   = hold_lvl[c][23:0];
      o.rms         = rt[23:0];
      o.clip        = latch[c];
      pending.push_back(o);
      blk_peak[c] = 0; blk_sum[c] = 0; count[c] = 0;
    endfunction

    task check(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result on channel %0d", got.out_channel));
        return;
      end
      e = pending.pop_front();
      n_results++;
      if (e.clip) n_clips++;
      if (got.out_channel !== e.out_channel)
        report($sformatf("out_channel %0d, want %0d", got.out_channel, e.out_channel));
      if (got.peak !== e.peak)
        report($sformatf("ch%0d peak %0d, want %0d", e.out_channel, got.peak, e.peak));
      if (got.peak_hold !== e.peak_hold)
        report($sformatf("ch%0d peak_hold %0d, want %0d", e.out_channel,
                         got.peak_hold, e.peak_hold));
      if (got.rms !== e.rms)
        report($sformatf("ch%0d rms %0d, want %0d", e.out_channel, got.rms, e.rms));
      if (got.clip !== e.clip)
        report($sformatf("ch%0d clip %0b, want %0b", e.out_channel, got.clip, e.clip));
    endtask
  endclass

  level_scoreboard sb = new();

  int burst_left = 0;
  int n_items = 0;
  int n_cfg = 0;
  int quiet = 0;
  int unsigned cyc = 0;

  // receiver stall pattern: free-running, moderate, sparse, square wave
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case (cyc[9:8])
      2'd0: pop <= 1'b1;
      2'd1: pop <= 1'($urandom_range(1));
      2'd2: pop <= ($urandom_range(7) == 0);
      default: pop <= cyc[3];
    endcase
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check(result);
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("timeout: no item moved in %0d cycles", WD_LIMIT);
      $display("audio_level_meter: mismatch");
      $finish;
    end
  end

  task send(in_t x);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    item <= x;
    do @(posedge clk); while (full);
    sb.note_input(x);
    n_items++;
  endtask

  task drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // clears and mid-block samples may still be in flight
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task write_reg(logic [2:0] idx, bit [23:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task setup(bit [23:0] act, bit [23:0] c, bit [23:0] pd, bit [23:0] hd,
             bit [23:0] hb, bit [23:0] thr, bit [23:0] ch);
    drain();
    write_reg(CFG_ACTIVE, act);
    write_reg(CFG_RMS_COEFF, c);
    write_reg(CFG_PEAK_DECAY, pd);
    write_reg(CFG_HOLD_DECAY, hd);
    write_reg(CFG_HOLD_BLK, hb);
    write_reg(CFG_CLIP_THR, thr);
    write_reg(CFG_CLIP_HOLD, ch);
  endtask

  function in_t mk(logic f, int c, int s, logic l);
    in_t x;
    x.func = f;
    x.channel = 3'(c);
    x.sample = 24'(s);
    x.last_in_block = l;
    return x;
  endfunction

  function in_t rand_item(int act, int loud);
    in_t x;
    x.func = ($urandom_range(15) == 0) ? FUNC_CLEAR : FUNC_SAMPLE;
    if (act == 0 || $urandom_range(7) == 0) x.channel = 3'($urandom_range(7));
    else x.channel = 3'($urandom_range(act - 1));
    case ($urandom_range(3))
      0: x.sample = 24'($urandom());
      1: x.sample = 24'($urandom_range(2000) - 1000);
      2: x.sample = ($urandom_range(1) ? 24'h7FFFFF : 24'h800000);
      default: x.sample = 24'(($urandom_range(1) ? loud : -loud) + $urandom_range(64) - 32);
    endcase
    x.last_in_block = ($urandom_range(3) == 0);
    return x;
  endfunction

  task rand_phase(int act, int loud, int count);
    repeat (count) send(rand_item(act, loud));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full-scale extremes, seeding, clear, idle-silence block
    setup(8, 1165, 60000, 60000, 100, 8388607, 0);
    send(mk(FUNC_SAMPLE, 0, 24'h7FFFFF, 1'b0));
    send(mk(FUNC_SAMPLE, 0, 24'h800000, 1'b1));
    send(mk(FUNC_SAMPLE, 1, 0, 1'b1));
    send(mk(FUNC_CLEAR, 0, 24'hFFFFFF, 1'b1));
    send(mk(FUNC_SAMPLE, 0, 1, 1'b1));
    send(mk(FUNC_SAMPLE, 7, -1, 1'b0));
    send(mk(FUNC_SAMPLE, 7, 24'h555555, 1'b1));
    send(mk(FUNC_SAMPLE, 0, 24'h2AAAAA, 1'b1));
    send(mk(FUNC_SAMPLE, 1, 24'h800000, 1'b1));

    // zero threshold latches every block, so the one-block clip hold never ages it out
    setup(8, 24'hFFFFFF, 65535, 65535, 65535, 0, 1);
    send(mk(FUNC_SAMPLE, 2, 100, 1'b1));
    send(mk(FUNC_SAMPLE, 2, -100, 1'b1));
    rand_phase(8, 4000000, 50);

    // inactive channels, threshold above full scale but one
    setup(3, 0, 0, 0, 0, 8388608, 65535);
    send(mk(FUNC_SAMPLE, 5, 1234, 1'b1));
    send(mk(FUNC_CLEAR, 6, 0, 1'b0));
    send(mk(FUNC_SAMPLE, 2, 24'h800000, 1'b1));
    rand_phase(3, 8388600, 50);

    setup(0, 5000, 30000, 30000, 1, 4000000, 2);
    rand_phase(0, 4000000, 20);

    setup(8, 1165, 60000, 60000, 100, 8388607, 0);
    rand_phase(8, 8388607, 50);

    setup(5, 24'($urandom()), 24'($urandom()), 24'($urandom()), 2, 100000, 3);
    rand_phase(5, 100000, 60);

    setup(8, 24'($urandom()), 24'($urandom()), 24'($urandom()),
          24'($urandom_range(5)), 24'($urandom()), 24'($urandom_range(4)));
    rand_phase(8, 2000000, 60);

    setup(1, 24'h800000, 65535, 0, 65535, 1, 65535);
    rand_phase(1, 1000, 40);

    setup(8, 1, 1, 65535, 3, 6000000, 1);
    rand_phase(8, 6000000, 60);

    drain();
    $display("covered %0d items, %0d register writes, %0d blocks closed (%0d clipped)",
             n_items, n_cfg, sb.n_results, sb.n_clips);
    if (sb.errors == 0)
      $display("audio_level_meter: match");
    else
      $display("audio_level_meter: mismatch");
    $finish;
  end

endmodule

// ===== audio_level_meter.f =====
+incdir+hdl
hdl/alm_pkg.sv
hdl/alm_fifo.sv
hdl/alm_front.sv
hdl/alm_root.sv
hdl/alm_back.sv
hdl/audio_level_meter.sv
dv/audio_level_meter_tb.sv
